FILE: src/fpap_pkg.sv
// Shared types, widths and constants for the FTP PORT argument parser.
// No dependencies; compile first.
package fpap_pkg;

    localparam int MAX_CHARS = 1024;
    localparam int CHAR_CNT_W = $clog2(MAX_CHARS + 1);

    localparam int CH_W = 8;
    localparam int ADDR_W = 32;
    localparam int PORT_W = 16;
    localparam int BYTE_W = 8;

    localparam logic [CH_W-1:0] CH_TERM = 8'h00;
    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE = 8'h39;

    localparam logic [2:0] ADDR_NUMS = 3'd4;
    localparam logic [1:0] PORT_NUMS = 2'd2;

    typedef struct packed {
        logic            fire;
        logic [CH_W-1:0] ch;
    } beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] host_addr;
        logic [PORT_W-1:0] host_port;
        logic              ok;
    } res_t;

endpackage

FILE: src/fpap_char_if.sv
// Character input channel: valid/ready handshake, one character per beat.
// Depends on fpap_pkg.
interface fpap_char_if;
    import fpap_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

FILE: src/fpap_result_if.sv
// Result channel: parsed address, port and ok flag, one result per beat.
// Depends on fpap_pkg.
interface fpap_result_if;
    import fpap_pkg::*;

    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] host_addr;
    logic [PORT_W-1:0] host_port;
    logic              ok;

    modport source (output valid, output host_addr, output host_port, output ok, input ready);
    modport sink (input valid, input host_addr, input host_port, input ok, output ready);
endinterface

FILE: src/fpap_field_acc.sv
// Per-character parse state: digit accumulation, number closing, address and
// port shift registers, character count. Depends on fpap_pkg.
module fpap_field_acc
(
    input  logic            clk,
    input  logic            rst_n,
    input  fpap_pkg::beat_t beat,
    output logic            term,
    output fpap_pkg::res_t  res
);
    import fpap_pkg::*;

    localparam logic [CHAR_CNT_W-1:0] CNT_MAX = CHAR_CNT_W'(MAX_CHARS);

    logic                  in_number_reg, in_number_next;
    logic [BYTE_W-1:0]     num_reg, num_next;
    logic [2:0]            addr_cnt_reg, addr_cnt_next;
    logic [1:0]            port_cnt_reg, port_cnt_next;
    logic [ADDR_W-1:0]     addr_acc_reg, addr_acc_next;
    logic [PORT_W-1:0]     port_acc_reg, port_acc_next;
    logic [CHAR_CNT_W-1:0] char_cnt_reg, char_cnt_next;

    logic              is_digit;
    logic [BYTE_W-1:0] digit;
    logic [BYTE_W-1:0] num_times10;

    assign term        = (beat.ch == CH_TERM);
    assign is_digit    = (beat.ch >= CH_ZERO) && (beat.ch <= CH_NINE);
    assign digit       = beat.ch - CH_ZERO;
    assign num_times10 = (num_reg << 3) + (num_reg << 1);

    assign res.host_addr = addr_acc_reg;
    assign res.host_port = port_acc_reg;
    assign res.ok        = (addr_cnt_reg == ADDR_NUMS) && (port_cnt_reg == PORT_NUMS);

    always_comb
    begin
        in_number_next = in_number_reg;
        num_next       = num_reg;
        addr_cnt_next  = addr_cnt_reg;
        port_cnt_next  = port_cnt_reg;
        addr_acc_next  = addr_acc_reg;
        port_acc_next  = port_acc_reg;
        char_cnt_next  = char_cnt_reg;
        if (beat.fire)
        begin
            if (term)
            begin
                in_number_next = 1'b0;
                num_next       = '0;
                addr_cnt_next  = '0;
                port_cnt_next  = '0;
                addr_acc_next  = '0;
                port_acc_next  = '0;
                char_cnt_next  = '0;
            end
            else if (char_cnt_reg < CNT_MAX)
            begin
                char_cnt_next = char_cnt_reg + 1'b1;
                if (is_digit)
                begin
                    num_next       = num_times10 + digit;
                    in_number_next = 1'b1;
                end
                else if (in_number_reg)
                begin
                    if (addr_cnt_reg < ADDR_NUMS)
                    begin
                        addr_acc_next = {addr_acc_reg[ADDR_W-BYTE_W-1:0], num_reg};
                        addr_cnt_next = addr_cnt_reg + 1'b1;
                    end
                    else if (port_cnt_reg < PORT_NUMS)
                    begin
                        port_acc_next = {port_acc_reg[PORT_W-BYTE_W-1:0], num_reg};
                        port_cnt_next = port_cnt_reg + 1'b1;
                    end
                    in_number_next = 1'b0;
                    num_next       = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_number_reg <= 1'b0;
            num_reg       <= '0;
            addr_cnt_reg  <= '0;
            port_cnt_reg  <= '0;
            addr_acc_reg  <= '0;
            port_acc_reg  <= '0;
            char_cnt_reg  <= '0;
        end
        else
        begin
            in_number_reg <= in_number_next;
            num_reg       <= num_next;
            addr_cnt_reg  <= addr_cnt_next;
            port_cnt_reg  <= port_cnt_next;
            addr_acc_reg  <= addr_acc_next;
            port_acc_reg  <= port_acc_next;
            char_cnt_reg  <= char_cnt_next;
        end
    end
endmodule

FILE: src/fpap_out_reg.sv
// Output register for parse results; drives the result channel.
// Depends on fpap_pkg and fpap_result_if.
module fpap_out_reg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  fpap_pkg::res_t        res,
    output logic                  free,
    fpap_result_if.source         result
);
    import fpap_pkg::*;

    logic valid_reg, valid_next;
    res_t data_reg;

    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (result.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= res;
    end

    assign result.valid     = valid_reg;
    assign result.host_addr = data_reg.host_addr;
    assign result.host_port = data_reg.host_port;
    assign result.ok        = data_reg.ok;
endmodule

FILE: src/ftp_port_argument_parser.sv
// Top level of the FTP PORT argument parser: input register, parse state,
// output register. Depends on fpap_pkg, fpap_char_if, fpap_result_if.
//
// Usage:
//   chars  : one character per beat; 0 terminates the argument string.
//   result : one beat per terminator with host_addr, host_port and ok.
// Throughput: one character per cycle while the result side keeps up.
// Path: an accepted terminator passes through the input register, and the
//   parse state then loads the output register directly, raising result.valid.
// Non-terminator characters produce no beat; they pass from the input
//   register into the parse state.
// Characters past MAX_CHARS are dropped until the next terminator.
// Reset (rst_n low, asynchronous) clears the parse state and all valids.
// Stall: when result.ready is low and a result is held, a terminator waits
//   in the input register; ordinary characters keep flowing until then.
//   chars.ready drops only while such a terminator is blocked.
module ftp_port_argument_parser
(
    input  logic          clk,
    input  logic          rst_n,
    fpap_char_if.sink     chars,
    fpap_result_if.source result
);
    import fpap_pkg::*;

    logic            in_valid_reg, in_valid_next;
    logic [CH_W-1:0] ch_reg;
    logic            advance;
    logic            term;
    logic            out_free;
    logic            accept;
    beat_t           beat;
    res_t            res;

    assign beat.fire = advance;
    assign beat.ch   = ch_reg;

    assign advance     = in_valid_reg && (!term || out_free);
    assign chars.ready = !in_valid_reg || advance;
    assign accept      = chars.valid && chars.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            ch_reg <= chars.ch;
    end

    fpap_field_acc u_field_acc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .beat  (beat),
        .term  (term),
        .res   (res)
    );

    fpap_out_reg u_out_reg
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && term),
        .res    (res),
        .free   (out_free),
        .result (result)
    );

    a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && term) |=> result.valid)
        else $error("terminator did not produce a result");

    a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(ch_reg)))
        else $error("blocked character lost or changed");

    a_only_term_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (term && result.valid && !result.ready))
        else $error("input stalled without a held result");
endmodule
